/* src/mtt_pkg.sv */
// ----------------------------------------------------------------------------
// mtt_pkg: shared types and constants for the tone channel bank
// Holds the event codes, sequencer states and the fractional root table.
// ----------------------------------------------------------------------------
`default_nettype none
package mtt_pkg;

    localparam int CHANNELS_DEF = 8;
    localparam int CH_W = 3;
    localparam logic [13:0] BEND_CENTER = 14'd8192;
    localparam logic [4:0] RANGE_RESET = 5'd2;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_NOTE_ON = 2'd1,
        OP_NOTE_OFF = 2'd2,
        OP_BEND = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MUL,
        ST_SCALE,
        ST_DONE
    } state_t;

    // Start request and result from the period unit.
    typedef struct packed {
        logic        start;
        logic [15:0] base;
        logic [13:0] bend;
        logic [4:0]  range;
    } bp_req_t;

    typedef struct packed {
        logic        done;
        logic [15:0] period;
    } bp_rsp_t;

    // Q30 values of 2^(2^(k-12)) for fractional bit k.
    function automatic logic [31:0] root_const(input logic [3:0] k);
        logic [31:0] r;
        begin
            case (k)
                4'd0: r = 32'd1073923544;
                4'd1: r = 32'd1074105294;
                4'd2: r = 32'd1074468888;
                4'd3: r = 32'd1075196443;
                4'd4: r = 32'd1076653033;
                4'd5: r = 32'd1079572136;
                4'd6: r = 32'd1085434106;
                4'd7: r = 32'd1097253708;
                4'd8: r = 32'd1121280440;
                4'd9: r = 32'd1170923762;
                4'd10: r = 32'd1276901417;
                4'd11: r = 32'd1518500250;
                default: r = 32'd1073741824;
            endcase
            return r;
        end
    endfunction

endpackage
`default_nettype wire

/* src/multichannel_tone_toggler.sv */
// ----------------------------------------------------------------------------
// multichannel_tone_toggler: bank of square-wave tone channels
// Takes tick, note on, note off and bend events; one result beat per event.
// ----------------------------------------------------------------------------
// A tick steps through the channels, one channel counter per cycle; note off and
// events that need no new period go straight to the result. Note on of an idle
// channel and bend of a held note wait for the period unit (12 root steps, one
// scale step, plus request, handoff and result).
// Throughput: one event at a time; s_tvalid is taken again once the result beat
// has moved into the output register. Reset is asynchronous, active low.
`default_nettype none
module multichannel_tone_toggler #(
    parameter int CHANNELS = mtt_pkg::CHANNELS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // operation, channel, note, base_period, bend
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // pin_levels, channel_active, active_note
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [4:0]  cfg_data
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNT_W = $clog2(CHANNELS + 1);

    mtt_pkg::state_t state_reg, state_next;
    logic [4:0]  range_reg;
    logic [1:0]  op_reg;
    logic [2:0]  ch_reg;
    logic [6:0]  note_reg;
    logic [15:0] base_reg;
    logic [13:0] bend_reg;
    logic [CNT_W-1:0] scan_reg, scan_next;

    logic [CHANNELS-1:0] valid_reg;
    logic [CHANNELS-1:0] pin_reg;
    logic [6:0]  held_reg [CHANNELS];
    logic [15:0] unbent_reg [CHANNELS];
    logic [15:0] bent_reg [CHANNELS];
    logic [15:0] cnt_reg [CHANNELS];
    logic [13:0] bendv_reg [CHANNELS];

    logic        out_valid_reg;
    logic [15:0] out_data_reg;

    mtt_pkg::bp_req_t req;
    mtt_pkg::bp_rsp_t rsp;

    logic ok;
    logic [IDX_W-1:0] ci, si;

    assign ok = 32'(ch_reg) < CHANNELS;
    assign ci = IDX_W'(ch_reg);
    assign si = scan_reg[IDX_W-1:0];

    mtt_period u_period (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        scan_next = scan_reg;
        case (state_reg)
            mtt_pkg::ST_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    state_next = mtt_pkg::ST_EXEC;
                    scan_next = '0;
                end
            end
            mtt_pkg::ST_EXEC:
            begin
                if (op_reg == mtt_pkg::OP_TICK)
                begin
                    if (32'(scan_reg) >= CHANNELS - 1)
                        state_next = mtt_pkg::ST_DONE;
                    else
                        scan_next = scan_reg + CNT_W'(1);
                end
                else if (ok && op_reg == mtt_pkg::OP_NOTE_ON && !valid_reg[ci])
                    state_next = mtt_pkg::ST_MUL;
                else if (ok && op_reg == mtt_pkg::OP_BEND && valid_reg[ci])
                    state_next = mtt_pkg::ST_MUL;
                else
                    state_next = mtt_pkg::ST_DONE;
            end
            mtt_pkg::ST_MUL:
                state_next = mtt_pkg::ST_SCALE;
            mtt_pkg::ST_SCALE:
            begin
                if (rsp.done)
                    state_next = mtt_pkg::ST_DONE;
            end
            mtt_pkg::ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                    state_next = mtt_pkg::ST_IDLE;
            end
            default:
                state_next = mtt_pkg::ST_IDLE;
        endcase
    end

    // Outputs and period requests.
    always_comb
    begin
        s_tready = (state_reg == mtt_pkg::ST_IDLE);
        cfg_ready = (state_reg == mtt_pkg::ST_IDLE);
        req.start = (state_reg == mtt_pkg::ST_MUL);
        req.range = range_reg;
        req.base = (op_reg == mtt_pkg::OP_NOTE_ON) ? base_reg : unbent_reg[ci];
        req.bend = (op_reg == mtt_pkg::OP_NOTE_ON) ? bendv_reg[ci] : bend_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mtt_pkg::ST_IDLE;
            scan_reg <= '0;
            range_reg <= mtt_pkg::RANGE_RESET;
            valid_reg <= '0;
            pin_reg <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                held_reg[i] <= '0;
                unbent_reg[i] <= '0;
                bent_reg[i] <= '0;
                cnt_reg[i] <= '0;
                bendv_reg[i] <= mtt_pkg::BEND_CENTER;
            end
        end
        else
        begin
            state_reg <= state_next;
            scan_reg <= scan_next;
            if (cfg_valid && cfg_ready)
                range_reg <= cfg_data;
            // A new result beat loads as the old one leaves, or into an empty slot.
            if (state_reg == mtt_pkg::ST_DONE && (!out_valid_reg || m_tready))
                out_valid_reg <= 1'b1;
            else if (m_tvalid && m_tready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                mtt_pkg::ST_EXEC:
                begin
                    if (op_reg == mtt_pkg::OP_TICK)
                    begin
                        if (valid_reg[si] && bent_reg[si] != 16'd0)
                        begin
                            if (cnt_reg[si] >= bent_reg[si])
                            begin
                                pin_reg[si] <= ~pin_reg[si];
                                cnt_reg[si] <= '0;
                            end
                            else
                                cnt_reg[si] <= cnt_reg[si] + 16'd1;
                        end
                    end
                    else if (ok && op_reg == mtt_pkg::OP_NOTE_ON && !valid_reg[ci])
                    begin
                        valid_reg[ci] <= 1'b1;
                        held_reg[ci] <= note_reg;
                        unbent_reg[ci] <= base_reg;
                    end
                    else if (ok && op_reg == mtt_pkg::OP_NOTE_OFF && valid_reg[ci]
                             && held_reg[ci] == note_reg)
                    begin
                        valid_reg[ci] <= 1'b0;
                        held_reg[ci] <= '0;
                        unbent_reg[ci] <= '0;
                        bent_reg[ci] <= '0;
                        cnt_reg[ci] <= '0;
                        pin_reg[ci] <= 1'b0;
                    end
                    else if (ok && op_reg == mtt_pkg::OP_BEND)
                        bendv_reg[ci] <= bend_reg;
                end
                mtt_pkg::ST_SCALE:
                begin
                    if (rsp.done)
                        bent_reg[ci] <= rsp.period;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Event capture and result register.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            op_reg <= s_tdata[1:0];
            ch_reg <= s_tdata[4:2];
            note_reg <= s_tdata[11:5];
            base_reg <= s_tdata[27:12];
            bend_reg <= s_tdata[41:28];
        end
        if (state_reg == mtt_pkg::ST_DONE && (!out_valid_reg || m_tready))
        begin
            for (int i = 0; i < 8; i++)
                out_data_reg[i] <= (i < CHANNELS) ? pin_reg[IDX_W'(i)] : 1'b0;
            out_data_reg[8] <= ok && valid_reg[ci];
            out_data_reg[15:9] <= (ok && valid_reg[ci]) ? held_reg[ci] : 7'd0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_data_reg;

endmodule
`default_nettype wire

/* src/mtt_period.sv */
// ----------------------------------------------------------------------------
// mtt_period: bent period unit
// Works out the bent half-period with one shared 32x32 multiplier,
// one fractional root bit per cycle, then base scaling and saturation.
// ----------------------------------------------------------------------------
`default_nettype none
module mtt_period (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire mtt_pkg::bp_req_t req,
    output mtt_pkg::bp_rsp_t     rsp
);

    logic        busy_reg, busy_next;
    logic [1:0]  phase_reg, phase_next;
    logic [3:0]  k_reg, k_next;
    logic [11:0] f_reg, f_next;
    logic signed [7:0] q_reg, q_next;
    logic [31:0] m_reg, m_next;
    logic [15:0] base_reg, base_next;
    logic [15:0] per_reg, per_next;
    logic        done_reg, done_next;

    // Exponent split: n = range*(8192-bend), e = floor(n/24).
    logic signed [15:0] bend_diff;
    logic signed [21:0] n_val;
    logic signed [21:0] n_off;
    logic [16:0]        e_div8;
    logic [34:0]        e_mul;
    logic [16:0]        e_pos;
    logic signed [18:0] e_val;
    logic [63:0]        prod;
    logic [15:0]        sat;
    logic [63:0]        shifted;

    assign bend_diff = $signed({2'b00, mtt_pkg::BEND_CENTER}) - $signed({2'b00, req.bend});
    assign n_val = $signed({17'd0, req.range}) * $signed({{6{bend_diff[15]}}, bend_diff});
    assign n_off = n_val + 22'sd480000;

    // The offset value is positive and below 2^20, so dividing by 24 is a shift
    // by 3 and a divide by 3 done as a multiply by ceil(2^18/3), exact here.
    assign e_div8 = 17'(n_off[21:3]);
    assign e_mul = 35'(e_div8) * 35'd87382;
    assign e_pos = e_mul[34:18];
    assign e_val = $signed({2'b00, e_pos}) - 19'sd20000;

    // Shared multiplier: root step or base scaling.
    always_comb
    begin
        if (phase_reg == 2'd1)
            prod = 64'(m_reg) * 64'(mtt_pkg::root_const(k_reg));
        else
            prod = 64'(m_reg) * 64'(base_reg);
    end

    always_comb
    begin
        if (q_reg >= 0)
            shifted = prod << q_reg[3:0];
        else
            shifted = prod >> (-q_reg);
        if (q_reg > 8'sd16)
            sat = (prod == 64'd0) ? 16'd1 : 16'hFFFF;
        else if (shifted[63:30] == 34'd0)
            sat = 16'd1;
        else if (shifted[63:46] != 18'd0)
            sat = 16'hFFFF;
        else
            sat = shifted[45:30];
    end

    always_comb
    begin
        busy_next = busy_reg;
        phase_next = phase_reg;
        k_next = k_reg;
        f_next = f_reg;
        q_next = q_reg;
        m_next = m_reg;
        base_next = base_reg;
        per_next = per_reg;
        done_next = 1'b0;
        if (!busy_reg)
        begin
            if (req.start)
            begin
                busy_next = 1'b1;
                phase_next = 2'd1;
                k_next = 4'd11;
                f_next = e_val[11:0];
                q_next = {e_val[18], e_val[18:12]};
                m_next = 32'h4000_0000;
                base_next = req.base;
            end
        end
        else if (phase_reg == 2'd1)
        begin
            if (f_reg[k_reg])
                m_next = prod[61:30];
            if (k_reg == 4'd0)
                phase_next = 2'd2;
            else
                k_next = k_reg - 4'd1;
        end
        else
        begin
            per_next = sat;
            done_next = 1'b1;
            busy_next = 1'b0;
            phase_next = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            phase_reg <= 2'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            phase_reg <= phase_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg <= k_next;
        f_reg <= f_next;
        q_reg <= q_next;
        m_reg <= m_next;
        base_reg <= base_next;
        per_reg <= per_next;
    end

    assign rsp.done = done_reg;
    assign rsp.period = per_reg;

endmodule
`default_nettype wire

/* src/mtt_checker.sv */
// ----------------------------------------------------------------------------
// mtt_checker: port-level checks for the tone channel bank
// Watches the handshakes of the top level and is bound to it.
// ----------------------------------------------------------------------------
`default_nettype none
module mtt_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic        cfg_ready
);

    // A stalled result beat holds its data.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // An accepted event blocks further input on the next cycle.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");

    // Configuration ready always matches event input ready.
    a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready == s_tready)
        else $error("config ready differs from input ready");

    // An inactive result never reports a note.
    a_note: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[8] |-> m_tdata[15:9] == 7'd0)
        else $error("idle channel shows a note");

endmodule

bind multichannel_tone_toggler mtt_checker u_mtt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_ready (cfg_ready)
);
`default_nettype wire
